[rtl/mstp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstp_pkg
// Shared types and constants for the maximum spanning tree parent block.
// ----------------------------------------------------------------------------
package mstp_pkg;

  localparam int NODE_W          = 6;
  localparam int EDGE_W          = 32;
  localparam int CNT_CFG_W       = 7;
  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_WEIGHT_BITS = 32;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-3:0]   REG_NODE_COUNT   = 1'b0;
  localparam logic [CNT_CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_INIT,
    OP_RELAX,
    OP_COMMIT
  } cell_op_t;

endpackage

[rtl/mstp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mstp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mstp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstp_cell
// One node of the tree build: keeps best edge, source, parent and tree flag,
// and passes the running best candidate on to the next cell.
// ----------------------------------------------------------------------------
module mstp_cell #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32,
  parameter int CELL_ID     = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mstp_pkg::cell_op_t             op,
  input  logic [$clog2(MAX_NODES)-1:0]   col,
  input  logic [$clog2(MAX_NODES)-1:0]   cur,
  input  logic [WEIGHT_BITS-1:0]         rd_weight,
  input  logic                           tok_found_in,
  input  logic [WEIGHT_BITS-1:0]         tok_weight_in,
  input  logic [$clog2(MAX_NODES)-1:0]   tok_index_in,
  output logic                           tok_found,
  output logic [WEIGHT_BITS-1:0]         tok_weight,
  output logic [$clog2(MAX_NODES)-1:0]   tok_index,
  output logic [$clog2(MAX_NODES)-1:0]   parent
);

  import mstp_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

  logic [WEIGHT_BITS-1:0] best;
  logic [IDX_W-1:0]       source;
  logic                   in_tree;

  logic                   hit;
  logic                   active;
  logic                   better;
  logic                   pass;
  logic                   take;
  logic [WEIGHT_BITS-1:0] cand;

  always_comb begin
    hit    = (col == MY_ID);
    active = hit && (op inside {OP_INIT, OP_RELAX});
    better = (best < rd_weight);
    if (op == OP_INIT) begin
      cand = rd_weight;
    end else begin
      cand = better ? rd_weight : best;
    end
    pass = (op == OP_RELAX) && in_tree;
    take = !pass && (!tok_found_in || (cand > tok_weight_in));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tree   <= 1'b0;
      tok_found <= 1'b0;
    end else begin
      case (op)
        OP_INIT: begin
          if (hit) begin
            best    <= rd_weight;
            source  <= '0;
            in_tree <= 1'b0;
          end
        end
        OP_RELAX: begin
          if (hit && !in_tree && better) begin
            best   <= rd_weight;
            source <= cur;
          end
        end
        OP_COMMIT: begin
          if (cur == MY_ID) begin
            parent  <= source;
            in_tree <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (active) begin
        tok_found  <= tok_found_in || !pass;
        tok_weight <= take ? cand : tok_weight_in;
        tok_index  <= take ? MY_ID : tok_index_in;
      end
    end
  end

endmodule

[rtl/max_spanning_tree_parents.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_spanning_tree_parents
// Dense Prim maximum spanning tree rooted at node 0, reporting one parent per
// node.
// ----------------------------------------------------------------------------
// usage:
//   the item channel (item_valid / item_stall), when not stalled, loads one
//   weight entry (row_node, col_node, edge_weight) per cycle to weight RAM
//   an item with last_entry set is stored and then starts the tree build over
//   node_count nodes (APB register 0, default 64)
//   build: one round per tree node after the root, each round streams one
//   RAM row through the cell chain, one column per cycle, then passes
//   through a drain state and a commit state
//   the result channel (result_valid / result_stall) then gives n parent
//   transactions in node order, one per cycle unless stalled
//   item_stall is high from the last entry until the last result is in the
//   output register; a stalled result holds and the build output waits
//   the next load may start while the final result still waits
//   reset clears control state and sets node_count to 64; weight RAM content
//   is kept and must be loaded for every entry the build reads
// ----------------------------------------------------------------------------
module max_spanning_tree_parents #(
  parameter int MAX_NODES   = mstp_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = mstp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mstp_pkg::PADDR_W-1:0]  paddr,
  input  logic [mstp_pkg::PDATA_W-1:0]  pwdata,
  output logic [mstp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [mstp_pkg::NODE_W-1:0]   row_node,
  input  logic [mstp_pkg::NODE_W-1:0]   col_node,
  input  logic [mstp_pkg::EDGE_W-1:0]   edge_weight,
  input  logic                          last_entry,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [mstp_pkg::NODE_W-1:0]   node_index,
  output logic [mstp_pkg::NODE_W-1:0]   parent_index,
  output logic                          is_root,
  output logic                          last_result
);

  import mstp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_LOAD,
    S_ISSUE,
    S_DRAIN,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state;

  logic [CNT_CFG_W-1:0] node_count;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     n_eff;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     col_q;
  logic [IDX_W-1:0]     cur_q;
  logic [IDX_W-1:0]     remain_q;
  logic [IDX_W-1:0]     oi_q;
  logic [IDX_W-1:0]     rd_col_q;
  cell_op_t             issue_op_q;
  cell_op_t             rd_op_q;
  cell_op_t             cell_op;
  logic [IDX_W-1:0]     cell_cur;

  logic                   item_accept;
  logic                   cfg_write;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] wr_word;
  logic [WEIGHT_BITS-1:0] rd_word;
  logic                   out_load;

  logic                   tok_found  [MAX_NODES];
  logic [WEIGHT_BITS-1:0] tok_weight [MAX_NODES];
  logic [IDX_W-1:0]       tok_index  [MAX_NODES];
  logic [IDX_W-1:0]       parent_arr [MAX_NODES];
  logic [IDX_W-1:0]       final_idx;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_NODE_COUNT);

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_NODE_COUNT) begin
      prdata = PDATA_W'(node_count);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, node_count} > (CNT_CFG_W + 1)'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(node_count);
    end
  end

  // weight RAM
  assign item_stall  = (state != S_LOAD);
  assign item_accept = item_valid && !item_stall;
  assign wr_word     = WEIGHT_BITS'(edge_weight);
  assign wr_en       = item_accept &&
                       ({1'b0, row_node} < (NODE_W + 1)'(MAX_NODES)) &&
                       ({1'b0, col_node} < (NODE_W + 1)'(MAX_NODES));
  assign wr_addr     = ADDR_W'(row_node[IDX_W-1:0]) * ADDR_W'(MAX_NODES) +
                       ADDR_W'(col_node[IDX_W-1:0]);
  assign rd_addr     = ADDR_W'(cur_q) * ADDR_W'(MAX_NODES) + ADDR_W'(col_q);

  mstp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // cell chain
  assign tok_found[0]  = 1'b0;
  assign tok_weight[0] = '0;
  assign tok_index[0]  = '0;
  assign parent_arr[0] = '0;

  assign cell_op  = (state == S_COMMIT) ? OP_COMMIT : rd_op_q;
  assign last_idx = IDX_W'(n_q - CNT_W'(1));
  assign final_idx = tok_index[last_idx];
  assign cell_cur = (state == S_COMMIT) ? final_idx : cur_q;

  for (genvar k = 1; k < MAX_NODES; k++) begin : g_cell
    mstp_cell #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .CELL_ID     (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .op            (cell_op),
      .col           (rd_col_q),
      .cur           (cell_cur),
      .rd_weight     (rd_word),
      .tok_found_in  (tok_found[k-1]),
      .tok_weight_in (tok_weight[k-1]),
      .tok_index_in  (tok_index[k-1]),
      .tok_found     (tok_found[k]),
      .tok_weight    (tok_weight[k]),
      .tok_index     (tok_index[k]),
      .parent        (parent_arr[k])
    );
  end

  assign out_load = (state == S_OUT) && (!result_valid || !result_stall);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      node_count   <= NODE_COUNT_RESET;
      rd_op_q      <= OP_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= pwdata[CNT_CFG_W-1:0];
      end
      rd_op_q <= (state == S_ISSUE) ? issue_op_q : OP_IDLE;
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (item_accept && last_entry) begin
            n_q      <= n_eff;
            col_q    <= IDX_W'(1);
            cur_q    <= '0;
            oi_q     <= '0;
            remain_q <= IDX_W'(n_eff - CNT_W'(1));
            issue_op_q <= OP_INIT;
            if (n_eff == CNT_W'(1)) begin
              state <= S_OUT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          rd_col_q <= col_q;
          col_q    <= col_q + IDX_W'(1);
          if (col_q == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          cur_q    <= final_idx;
          remain_q <= remain_q - IDX_W'(1);
          col_q    <= IDX_W'(1);
          if (remain_q == IDX_W'(1)) begin
            state <= S_OUT;
          end else begin
            issue_op_q <= OP_RELAX;
            state      <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            result_valid <= 1'b1;
            node_index   <= NODE_W'(oi_q);
            parent_index <= (oi_q == '0) ? '0 : NODE_W'(parent_arr[oi_q]);
            is_root      <= (oi_q == '0);
            last_result  <= (oi_q == last_idx);
            oi_q         <= oi_q + IDX_W'(1);
            if (oi_q == last_idx) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_commit_valid : assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (tok_found[last_idx] && final_idx != '0))
    else $error("commit without a valid candidate");

  a_rounds_left : assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE || state == S_DRAIN || state == S_COMMIT) |-> (remain_q != '0))
    else $error("tree round with no node left");

  a_issue_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (col_q != '0 && col_q <= last_idx))
    else $error("column out of range during issue");

  a_out_done : assert property (@(posedge clk) disable iff (rst)
    (out_load && oi_q == last_idx) |=> (result_valid && last_result && state == S_LOAD))
    else $error("final record not flagged");
`endif

endmodule
